FILE: src/tsprmb_pkg.sv
// ----------------------------------------------------------------------------
// TSP reduced matrix bound package
// Shared constants, element format and memory port types.
// ----------------------------------------------------------------------------
package tsprmb_pkg;

    localparam int MAX_CITIES = 8;
    localparam int IDX_W      = $clog2(MAX_CITIES);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_BITS = 16;
    localparam int ELEM_W     = ENTRY_BITS + 1;
    localparam int BOUND_W    = 24;
    localparam int ACC_W      = BOUND_W + 2;
    localparam int NCFG_W     = 4;

    localparam logic [NCFG_W-1:0]  N_CITIES_RESET = NCFG_W'(8);
    localparam logic [CNT_W-1:0]   SIDE_MAX       = CNT_W'(MAX_CITIES);
    localparam logic [BOUND_W-1:0] BOUND_MAX      = {BOUND_W{1'b1}};

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_EXPAND = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic KIND_BOUND = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // An element is an infinite flag above the cost value.
    typedef struct packed {
        logic                  inf;
        logic [ENTRY_BITS-1:0] value;
    } elem_t;

    localparam elem_t ELEM_INF = '{inf: 1'b1, value: '0};

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        elem_t             data;
    } mem_wr_t;

endpackage

FILE: src/tsprmb_mem.sv
// ----------------------------------------------------------------------------
// Cost matrix memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsprmb_mem (
    input  logic                          clk,
    input  tsprmb_pkg::mem_wr_t           wr,
    input  logic [tsprmb_pkg::ADDR_W-1:0] rd_addr,
    output tsprmb_pkg::elem_t             rd_data
);
    import tsprmb_pkg::*;

    elem_t mem [MAX_CITIES*MAX_CITIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/tsprmb_alu.sv
// ----------------------------------------------------------------------------
// Reduction compare and subtract unit
// Masks one element, folds it into a running minimum and subtracts a minimum.
// ----------------------------------------------------------------------------
module tsprmb_alu (
    input  tsprmb_pkg::elem_t elem,
    input  logic              masked,
    input  tsprmb_pkg::elem_t min_in,
    output tsprmb_pkg::elem_t min_out,
    output tsprmb_pkg::elem_t sub_out
);
    import tsprmb_pkg::*;

    elem_t eff;

    always_comb
    begin
        eff = masked ? ELEM_INF : elem;

        if (!eff.inf && (min_in.inf || (eff.value < min_in.value)))
        begin
            min_out = eff;
        end
        else
        begin
            min_out = min_in;
        end

        if (eff.inf)
        begin
            sub_out = ELEM_INF;
        end
        else if (min_in.inf)
        begin
            sub_out = eff;
        end
        else
        begin
            sub_out = '{inf: 1'b0, value: eff.value - min_in.value};
        end
    end

endmodule

FILE: src/tsprmb_seq.sv
// ----------------------------------------------------------------------------
// Reduction sequencer
// Walks the matrix line by line, drives the shared unit and holds the result.
// ----------------------------------------------------------------------------
module tsprmb_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [tsprmb_pkg::NCFG_W-1:0]      n_cities,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         mode,
    input  logic [tsprmb_pkg::IDX_W-1:0]       entry_row,
    input  logic [tsprmb_pkg::IDX_W-1:0]       entry_col,
    input  logic [tsprmb_pkg::ENTRY_BITS-1:0]  entry_value,
    input  logic                               entry_infinite,
    input  logic [tsprmb_pkg::IDX_W-1:0]       from_city,
    input  logic [tsprmb_pkg::IDX_W-1:0]       to_city,
    input  logic                               is_root,
    input  logic [tsprmb_pkg::BOUND_W-1:0]     parent_cost,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic                               result_kind,
    output logic [tsprmb_pkg::BOUND_W-1:0]     bound_cost,
    output logic                               cost_saturated,
    output logic                               edge_absent,
    output logic [tsprmb_pkg::ENTRY_BITS-1:0]  read_value,
    output logic                               read_infinite,
    output tsprmb_pkg::mem_wr_t                mem_wr,
    output logic [tsprmb_pkg::ADDR_W-1:0]      mem_rd_addr,
    input  tsprmb_pkg::elem_t                  mem_rd_data
);
    import tsprmb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_EDGE,
        ST_RMIN,
        ST_RSUB,
        ST_CMIN,
        ST_CSUB,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        line_reg, line_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    elem_t                   min_reg, min_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [IDX_W-1:0]        from_reg, from_next;
    logic [IDX_W-1:0]        to_reg, to_next;
    logic                    root_reg, root_next;
    logic                    from_ok_reg, from_ok_next;
    logic                    to_ok_reg, to_ok_next;
    logic                    absent_reg, absent_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [ADDR_W-1:0]       prev_addr_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    kind_reg, kind_next;
    logic [BOUND_W-1:0]      bound_reg, bound_next;
    logic                    sat_reg, sat_next;
    logic                    edge_absent_reg, edge_absent_next;
    logic [ENTRY_BITS-1:0]   rd_value_reg, rd_value_next;
    logic                    rd_inf_reg, rd_inf_next;

    logic [CNT_W-1:0]        side;
    logic                    accept;
    logic                    slot_free;
    logic                    proc;
    logic                    last;
    logic                    last_line;
    logic                    masked;
    logic [IDX_W-1:0]        prev_row;
    logic [IDX_W-1:0]        prev_col;
    elem_t                   alu_min;
    elem_t                   alu_sub;

    assign side      = (n_cities > NCFG_W'(MAX_CITIES)) ? SIDE_MAX : CNT_W'(n_cities);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign proc      = (k_reg != '0);
    assign last      = (k_reg == n_reg);
    assign last_line = ((line_reg + CNT_W'(1)) == n_reg);
    assign prev_row  = prev_addr_reg[ADDR_W-1:IDX_W];
    assign prev_col  = prev_addr_reg[IDX_W-1:0];

    // Row from_city and column to_city are masked for a child, entry
    // [to_city][0] for every expansion; masking is applied as lines are read.
    assign masked = (!root_reg && ((from_ok_reg && (prev_row == from_reg))
                                || (to_ok_reg && (prev_col == to_reg))))
                 || (to_ok_reg && (prev_row == to_reg) && (prev_col == '0));

    tsprmb_alu u_alu (
        .elem    (mem_rd_data),
        .masked  (masked),
        .min_in  (min_reg),
        .min_out (alu_min),
        .sub_out (alu_sub)
    );

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mem_rd_addr = (mode == MODE_READ) ? {entry_row, entry_col}
                                                  : {from_city, to_city};
            end
            ST_RMIN, ST_RSUB:
            begin
                mem_rd_addr = {line_reg[IDX_W-1:0], k_reg[IDX_W-1:0]};
            end
            ST_CMIN, ST_CSUB:
            begin
                mem_rd_addr = {k_reg[IDX_W-1:0], line_reg[IDX_W-1:0]};
            end
            default:
            begin
                mem_rd_addr = addr_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        line_next        = line_reg;
        k_next           = k_reg;
        min_next         = min_reg;
        acc_next         = acc_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        root_next        = root_reg;
        from_ok_next     = from_ok_reg;
        to_ok_next       = to_ok_reg;
        absent_next      = absent_reg;
        addr_next        = addr_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        kind_next        = kind_reg;
        bound_next       = bound_reg;
        sat_next         = sat_reg;
        edge_absent_next = edge_absent_reg;
        rd_value_next    = rd_value_reg;
        rd_inf_next      = rd_inf_reg;
        mem_wr           = '{en: 1'b0, addr: prev_addr_reg, data: alu_sub};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = {entry_row, entry_col};
                        mem_wr.data = entry_infinite ? ELEM_INF
                                    : elem_t'{inf: 1'b0, value: entry_value};
                    end
                    else if (mode == MODE_READ)
                    begin
                        addr_next  = {entry_row, entry_col};
                        state_next = ST_RD_WAIT;
                    end
                    else if (mode == MODE_EXPAND)
                    begin
                        n_next       = side;
                        from_next    = from_city;
                        to_next      = to_city;
                        root_next    = is_root;
                        from_ok_next = (CNT_W'(from_city) < side);
                        to_ok_next   = (CNT_W'(to_city) < side);
                        acc_next     = ACC_W'(parent_cost);
                        state_next   = ST_EDGE;
                    end
                end
            end

            ST_RD_WAIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_READ;
                    bound_next       = '0;
                    sat_next         = 1'b0;
                    edge_absent_next = 1'b0;
                    rd_value_next    = mem_rd_data.inf ? '0 : mem_rd_data.value;
                    rd_inf_next      = mem_rd_data.inf;
                    state_next       = ST_IDLE;
                end
            end

            ST_EDGE:
            begin
                if (root_reg)
                begin
                    absent_next = 1'b0;
                end
                else if (from_ok_reg && to_ok_reg)
                begin
                    absent_next = mem_rd_data.inf;
                    if (!mem_rd_data.inf)
                    begin
                        acc_next = acc_reg + ACC_W'(mem_rd_data.value);
                    end
                end
                else
                begin
                    absent_next = 1'b1;
                end
                line_next  = '0;
                k_next     = '0;
                min_next   = ELEM_INF;
                state_next = (n_reg == '0) ? ST_FINISH : ST_RMIN;
            end

            ST_RMIN, ST_CMIN:
            begin
                if (proc)
                begin
                    min_next = alu_min;
                end
                if (last)
                begin
                    if (!alu_min.inf)
                    begin
                        acc_next = acc_reg + ACC_W'(alu_min.value);
                    end
                    k_next     = '0;
                    state_next = (state_reg == ST_RMIN) ? ST_RSUB : ST_CSUB;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end

            ST_RSUB, ST_CSUB:
            begin
                mem_wr.en = proc;
                if (last)
                begin
                    k_next    = '0;
                    min_next  = ELEM_INF;
                    line_next = line_reg + CNT_W'(1);
                    if (state_reg == ST_RSUB)
                    begin
                        if (last_line)
                        begin
                            line_next  = '0;
                            state_next = ST_CMIN;
                        end
                        else
                        begin
                            state_next = ST_RMIN;
                        end
                    end
                    else
                    begin
                        state_next = last_line ? ST_FINISH : ST_CMIN;
                    end
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_BOUND;
                    sat_next         = (acc_reg > ACC_W'(BOUND_MAX));
                    bound_next       = sat_next ? BOUND_MAX : acc_reg[BOUND_W-1:0];
                    edge_absent_next = absent_reg;
                    rd_value_next    = '0;
                    rd_inf_next      = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            n_reg         <= '0;
            line_reg      <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            n_reg         <= n_next;
            line_reg      <= line_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg         <= min_next;
        from_reg        <= from_next;
        to_reg          <= to_next;
        root_reg        <= root_next;
        from_ok_reg     <= from_ok_next;
        to_ok_reg       <= to_ok_next;
        absent_reg      <= absent_next;
        addr_reg        <= addr_next;
        prev_addr_reg   <= mem_rd_addr;
        kind_reg        <= kind_next;
        bound_reg       <= bound_next;
        sat_reg         <= sat_next;
        edge_absent_reg <= edge_absent_next;
        rd_value_reg    <= rd_value_next;
        rd_inf_reg      <= rd_inf_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign result_kind    = kind_reg;
    assign bound_cost     = bound_reg;
    assign cost_saturated = sat_reg;
    assign edge_absent    = edge_absent_reg;
    assign read_value     = rd_value_reg;
    assign read_infinite  = rd_inf_reg;

    // A new response only ever comes from the two result states.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_FINISH
                               || $past(state_reg) == ST_RD_WAIT))
        else $error("response raised outside a result state");

    // The matrix is written only by a load or a subtract pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> (state_reg == ST_IDLE || state_reg == ST_RSUB
                    || state_reg == ST_CSUB))
        else $error("matrix written outside a load or subtract pass");

    // The element counter never runs past the active side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMIN || state_reg == ST_RSUB || state_reg == ST_CMIN
         || state_reg == ST_CSUB) |-> (k_reg <= n_reg && line_reg < n_reg))
        else $error("line or element counter beyond the active side");

    // A saturated bound is reported at the top of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && sat_reg) |-> (bound_reg == BOUND_MAX && kind_reg == KIND_BOUND))
        else $error("saturated bound not at its maximum");

endmodule

FILE: src/tsp_reduced_matrix_bound_core.sv
// ----------------------------------------------------------------------------
// TSP reduced matrix bound core
// Branch-and-bound lower-bound kernel: loads a cost matrix, reduces it for an
// expanded node and returns the new bound or a reduced entry.
//
//   Channel    Handshake               Contents
//   request    req_valid / req_ready   mode, entry, expansion fields
//   response   rsp_valid / rsp_ready   bound or read entry
//   config     cfg_wr_en               n_cities, no wait
//
// A load gives no response. An expansion makes one memory read per cycle
// through the shared compare and subtract unit, with writes only in the
// subtract passes: a minimum pass and a subtract pass for each row and column.
// req_ready is low while an item is in work; a held response stalls only the
// finish of the next read or expansion. Reset clears control state; the
// matrix holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
module tsp_reduced_matrix_bound_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tsprmb_pkg::NCFG_W-1:0]      cfg_wr_data,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         mode,
    input  logic [tsprmb_pkg::IDX_W-1:0]       entry_row,
    input  logic [tsprmb_pkg::IDX_W-1:0]       entry_col,
    input  logic [tsprmb_pkg::ENTRY_BITS-1:0]  entry_value,
    input  logic                               entry_infinite,
    input  logic [tsprmb_pkg::IDX_W-1:0]       from_city,
    input  logic [tsprmb_pkg::IDX_W-1:0]       to_city,
    input  logic                               is_root,
    input  logic [tsprmb_pkg::BOUND_W-1:0]     parent_cost,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic                               result_kind,
    output logic [tsprmb_pkg::BOUND_W-1:0]     bound_cost,
    output logic                               cost_saturated,
    output logic                               edge_absent,
    output logic [tsprmb_pkg::ENTRY_BITS-1:0]  read_value,
    output logic                               read_infinite
);
    import tsprmb_pkg::*;

    logic [NCFG_W-1:0] n_cities_reg;
    mem_wr_t           mem_wr;
    logic [ADDR_W-1:0] mem_rd_addr;
    elem_t             mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cities_reg <= N_CITIES_RESET;
        end
        else if (cfg_wr_en)
        begin
            n_cities_reg <= cfg_wr_data;
        end
    end

    tsprmb_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tsprmb_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .n_cities       (n_cities_reg),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .mode           (mode),
        .entry_row      (entry_row),
        .entry_col      (entry_col),
        .entry_value    (entry_value),
        .entry_infinite (entry_infinite),
        .from_city      (from_city),
        .to_city        (to_city),
        .is_root        (is_root),
        .parent_cost    (parent_cost),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .result_kind    (result_kind),
        .bound_cost     (bound_cost),
        .cost_saturated (cost_saturated),
        .edge_absent    (edge_absent),
        .read_value     (read_value),
        .read_infinite  (read_infinite),
        .mem_wr         (mem_wr),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

endmodule

FILE: test/tsp_reduced_matrix_bound_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TSP reduced matrix bound core testbench
// Loads cost matrices of many side lengths, expands root and child nodes and
// reads back reduced entries. Every response is compared with an in-bench
// masking and reduction model, or a directed row's answer. Both channels idle
// and stall at random, and one long response hold-off backs the core up.
// ----------------------------------------------------------------------------
module tsp_reduced_matrix_bound_core_test;

    import tsprmb_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int RANDOM_REQUESTS  = 850;
    localparam int DRAIN_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 300;
    localparam int HOLD_CYCLES      = 400;
    localparam int PRESSURE_EPISODE = 4;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int MAX_REPORTS      = 50;

    typedef struct packed {
        logic [1:0]            mode;
        logic [IDX_W-1:0]      entry_row;
        logic [IDX_W-1:0]      entry_col;
        logic [ENTRY_BITS-1:0] entry_value;
        logic                  entry_infinite;
        logic [IDX_W-1:0]      from_city;
        logic [IDX_W-1:0]      to_city;
        logic                  is_root;
        logic [BOUND_W-1:0]    parent_cost;
    } tsp_req_t;

    typedef struct packed {
        logic                  result_kind;
        logic [BOUND_W-1:0]    bound_cost;
        logic                  cost_saturated;
        logic                  edge_absent;
        logic [ENTRY_BITS-1:0] read_value;
        logic                  read_infinite;
    } tsp_rsp_t;

    typedef struct {
        tsp_req_t req;
        bit       typed;
        tsp_rsp_t want;
    } stim_row_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [NCFG_W-1:0]     cfg_wr_data    = '0;
    logic                  req_valid      = 1'b0;
    logic                  req_ready;
    logic [1:0]            mode           = MODE_LOAD;
    logic [IDX_W-1:0]      entry_row      = '0;
    logic [IDX_W-1:0]      entry_col      = '0;
    logic [ENTRY_BITS-1:0] entry_value    = '0;
    logic                  entry_infinite = 1'b0;
    logic [IDX_W-1:0]      from_city      = '0;
    logic [IDX_W-1:0]      to_city        = '0;
    logic                  is_root        = 1'b0;
    logic [BOUND_W-1:0]    parent_cost    = '0;
    logic                  rsp_valid;
    logic                  rsp_ready      = 1'b0;
    logic                  result_kind;
    logic [BOUND_W-1:0]    bound_cost;
    logic                  cost_saturated;
    logic                  edge_absent;
    logic [ENTRY_BITS-1:0] read_value;
    logic                  read_infinite;

    elem_t             cost_model [MAX_CITIES][MAX_CITIES];
    bit                entry_loaded [MAX_CITIES][MAX_CITIES];
    logic [NCFG_W-1:0] n_cities_model = N_CITIES_RESET;
    tsp_rsp_t          expected_answers [$];
    tsp_rsp_t          oldest_answer;
    stim_row_t         directed_rows [$];
    int                send_idle_pct   = 0;
    int                rsp_stall_pct   = 0;
    int                rsp_hold_cycles = 0;
    int                mismatch_count  = 0;
    int                stall_cycles    = 0;
    int                requests_sent   = 0;

    tsp_reduced_matrix_bound_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .mode           (mode),
        .entry_row      (entry_row),
        .entry_col      (entry_col),
        .entry_value    (entry_value),
        .entry_infinite (entry_infinite),
        .from_city      (from_city),
        .to_city        (to_city),
        .is_root        (is_root),
        .parent_cost    (parent_cost),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .result_kind    (result_kind),
        .bound_cost     (bound_cost),
        .cost_saturated (cost_saturated),
        .edge_absent    (edge_absent),
        .read_value     (read_value),
        .read_infinite  (read_infinite)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int active_side();
        return (n_cities_model < MAX_CITIES) ? int'(n_cities_model) : MAX_CITIES;
    endfunction

    function automatic tsp_req_t random_request(input logic [1:0] op);
        logic [63:0] bits;
        tsp_req_t    req;
        bits     = {$urandom(), $urandom()};
        req      = bits[$bits(tsp_req_t)-1:0];
        req.mode = op;
        return req;
    endfunction

    function automatic tsp_req_t load_req(input int r, input int c, input int v, input bit inf);
        tsp_req_t req;
        req                = random_request(MODE_LOAD);
        req.entry_row      = IDX_W'(r);
        req.entry_col      = IDX_W'(c);
        req.entry_value    = ENTRY_BITS'(v);
        req.entry_infinite = inf;
        return req;
    endfunction

    function automatic tsp_req_t expand_req(input int from, input int to, input bit root,
                                            input int parent);
        tsp_req_t req;
        req             = random_request(MODE_EXPAND);
        req.from_city   = IDX_W'(from);
        req.to_city     = IDX_W'(to);
        req.is_root     = root;
        req.parent_cost = BOUND_W'(parent);
        return req;
    endfunction

    function automatic tsp_req_t read_req(input int r, input int c);
        tsp_req_t req;
        req           = random_request(MODE_READ);
        req.entry_row = IDX_W'(r);
        req.entry_col = IDX_W'(c);
        return req;
    endfunction

    function automatic tsp_rsp_t bound_rsp(input logic [BOUND_W-1:0] cost, input bit sat,
                                           input bit absent);
        tsp_rsp_t rsp;
        rsp                = '0;
        rsp.result_kind    = KIND_BOUND;
        rsp.bound_cost     = cost;
        rsp.cost_saturated = sat;
        rsp.edge_absent    = absent;
        return rsp;
    endfunction

    function automatic tsp_rsp_t read_rsp(input logic [ENTRY_BITS-1:0] v, input bit inf);
        tsp_rsp_t rsp;
        rsp               = '0;
        rsp.result_kind   = KIND_READ;
        rsp.read_value    = v;
        rsp.read_infinite = inf;
        return rsp;
    endfunction

    function automatic int random_cost();
        case ($urandom_range(3))
            0:       return $urandom_range(15);
            1:       return $urandom_range(65535);
            2:       return $urandom_range(65535, 65500);
            default: return $urandom_range(1000);
        endcase
    endfunction

    function automatic int random_parent();
        case ($urandom_range(2))
            0:       return $urandom_range(1000);
            1:       return $urandom_range(24'hFFFFFF);
            default: return 24'hFFFFFF - $urandom_range(300000);
        endcase
    endfunction

    task automatic add_row(input tsp_req_t req, input bit typed, input tsp_rsp_t want);
        stim_row_t row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Applies one request to the matrix copy and returns the response it causes.
    task automatic predict_matrix_op(input tsp_req_t req, output bit answered,
                                     output tsp_rsp_t answer);
        int          side;
        int unsigned total;
        bit          absent;
        elem_t       least;
        elem_t       e;
        answered = 1'b0;
        answer   = '0;
        side     = active_side();
        case (req.mode)
            MODE_LOAD:
            begin
                cost_model[req.entry_row][req.entry_col] =
                    req.entry_infinite ? ELEM_INF : {1'b0, req.entry_value};
                entry_loaded[req.entry_row][req.entry_col] = 1'b1;
            end
            MODE_READ:
            begin
                e        = cost_model[req.entry_row][req.entry_col];
                answered = 1'b1;
                answer   = read_rsp(e.inf ? '0 : e.value, e.inf);
            end
            MODE_EXPAND:
            begin
                total  = req.parent_cost;
                absent = 1'b0;
                if (!req.is_root)
                begin
                    if (req.from_city < side && req.to_city < side
                        && !cost_model[req.from_city][req.to_city].inf)
                        total += cost_model[req.from_city][req.to_city].value;
                    else
                        absent = 1'b1;
                    for (int k = 0; k < side; k++)
                    begin
                        if (req.from_city < side)
                            cost_model[req.from_city][k] = ELEM_INF;
                        if (req.to_city < side)
                            cost_model[k][req.to_city] = ELEM_INF;
                    end
                end
                if (req.to_city < side)
                    cost_model[req.to_city][0] = ELEM_INF;
                // Rows are reduced first, then columns.
                for (int pass = 0; pass < 2; pass++)
                begin
                    for (int j = 0; j < side; j++)
                    begin
                        least = ELEM_INF;
                        for (int k = 0; k < side; k++)
                        begin
                            e = (pass == 0) ? cost_model[j][k] : cost_model[k][j];
                            if (!e.inf && (least.inf || e.value < least.value))
                                least = e;
                        end
                        if (!least.inf)
                        begin
                            total += least.value;
                            for (int k = 0; k < side; k++)
                            begin
                                if (pass == 0 && !cost_model[j][k].inf)
                                    cost_model[j][k].value -= least.value;
                                if (pass == 1 && !cost_model[k][j].inf)
                                    cost_model[k][j].value -= least.value;
                            end
                        end
                    end
                end
                answered = 1'b1;
                answer   = bound_rsp((total > BOUND_MAX) ? BOUND_MAX : BOUND_W'(total),
                                     total > BOUND_MAX, absent);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_request(input tsp_req_t req, input bit typed, input tsp_rsp_t want);
        bit       answered;
        tsp_rsp_t answer;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        {mode, entry_row, entry_col, entry_value, entry_infinite,
         from_city, to_city, is_root, parent_cost} <= req;
        do
            @(posedge clk);
        while (!req_ready);
        predict_matrix_op(req, answered, answer);
        if (answered)
            expected_answers.push_back(typed ? want : answer);
        @(negedge clk);
    endtask

    task automatic set_n_cities(input logic [NCFG_W-1:0] value);
        req_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        n_cities_model  = value;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch("response with nothing pending", result_kind, 0);
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                check_field("result_kind", result_kind, oldest_answer.result_kind);
                check_field("bound_cost", bound_cost, oldest_answer.bound_cost);
                check_field("cost_saturated", cost_saturated, oldest_answer.cost_saturated);
                check_field("edge_absent", edge_absent, oldest_answer.edge_absent);
                check_field("read_value", read_value, oldest_answer.read_value);
                check_field("read_infinite", read_infinite, oldest_answer.read_infinite);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        tsp_rsp_t          no_answer;
        int                side;
        int                ops;
        int                pick;
        int                r;
        int                c;
        int                episode;
        logic [NCFG_W-1:0] n_pick;
        no_answer = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        set_n_cities(NCFG_W'(2));

        add_row(load_req(0, 0, 0, 1'b1), 1'b0, no_answer);
        add_row(load_req(0, 1, 65535, 1'b0), 1'b0, no_answer);
        add_row(load_req(1, 0, 65535, 1'b0), 1'b0, no_answer);
        add_row(load_req(1, 1, 65535, 1'b1), 1'b0, no_answer);
        add_row(expand_req(7, 0, 1'b1, 24'hFFFFFF), 1'b1, bound_rsp(BOUND_MAX, 1'b1, 1'b0));
        add_row(read_req(0, 1), 1'b1, read_rsp(0, 1'b0));
        add_row(read_req(1, 1), 1'b1, read_rsp(0, 1'b1));
        add_row(load_req(0, 1, 5, 1'b0), 1'b0, no_answer);
        add_row(load_req(1, 0, 7, 1'b0), 1'b0, no_answer);
        add_row(expand_req(0, 1, 1'b0, 0), 1'b1, bound_rsp(5, 1'b0, 1'b0));
        add_row(expand_req(0, 1, 1'b0, 100), 1'b1, bound_rsp(100, 1'b0, 1'b1));
        add_row(expand_req(5, 1, 1'b0, 0), 1'b1, bound_rsp(0, 1'b0, 1'b1));
        add_row(tsp_req_t'('1), 1'b0, no_answer);
        add_row(load_req(7, 7, 65535, 1'b1), 1'b0, no_answer);
        add_row(read_req(7, 7), 1'b1, read_rsp(0, 1'b1));
        add_row(load_req(6, 5, 0, 1'b0), 1'b0, no_answer);
        add_row(read_req(6, 5), 1'b1, read_rsp(0, 1'b0));
        add_row(load_req(3, 4, 16'hAAAA, 1'b0), 1'b0, no_answer);
        add_row(read_req(3, 4), 1'b1, read_rsp(16'hAAAA, 1'b0));
        add_row(load_req(0, 0, 3, 1'b0), 1'b0, no_answer);
        add_row(load_req(0, 1, 9, 1'b0), 1'b0, no_answer);
        add_row(load_req(1, 0, 4, 1'b0), 1'b0, no_answer);
        add_row(load_req(1, 1, 8, 1'b0), 1'b0, no_answer);
        add_row(expand_req(0, 1, 1'b1, 1000), 1'b0, no_answer);
        add_row(read_req(1, 1), 1'b0, no_answer);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        episode = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            case (episode % 4)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 83; end
                default: begin send_idle_pct = 7;  rsp_stall_pct = 7;  end
            endcase
            case (episode)
                0:       n_pick = NCFG_W'(15);
                1:       n_pick = NCFG_W'(0);
                2:       n_pick = NCFG_W'(1);
                3:       n_pick = NCFG_W'(8);
                default:
                begin
                    case ($urandom_range(15))
                        0:       n_pick = NCFG_W'($urandom_range(1));
                        1:       n_pick = NCFG_W'(8);
                        2:       n_pick = NCFG_W'($urandom_range(15, 9));
                        default: n_pick = NCFG_W'($urandom_range(7, 2));
                    endcase
                end
            endcase
            set_n_cities(n_pick);
            side = active_side();

            // A fresh matrix for the active area, mostly with an infinite diagonal.
            for (r = 0; r < side; r++)
            begin
                for (c = 0; c < side; c++)
                begin
                    send_request(load_req(r, c, random_cost(),
                                          (r == c) ? ($urandom_range(4) != 0)
                                                   : ($urandom_range(5) == 0)),
                                 1'b0, no_answer);
                    requests_sent++;
                end
            end

            if (episode == PRESSURE_EPISODE)
            begin
                rsp_hold_cycles = HOLD_CYCLES;
                ops             = 40;
            end
            else
            begin
                ops = $urandom_range(12, 4);
            end

            repeat (ops)
            begin
                pick = $urandom_range(99);
                if (side > 0 && $urandom_range(7) != 0)
                begin
                    r = $urandom_range(side - 1);
                    c = $urandom_range(side - 1);
                end
                else
                begin
                    r = $urandom_range(7);
                    c = $urandom_range(7);
                end
                if (pick < 10)
                begin
                    send_request(random_request(MODE_NONE), 1'b0, no_answer);
                end
                else
                begin
                    requests_sent++;
                    if (pick < 45)
                        send_request(expand_req(r, c, $urandom_range(4) == 0, random_parent()),
                                     1'b0, no_answer);
                    else if (pick < 75 && entry_loaded[r][c])
                        send_request(read_req(r, c), 1'b0, no_answer);
                    else
                        send_request(load_req(r, c, random_cost(), $urandom_range(4) == 0),
                                     1'b0, no_answer);
                end
            end
            episode++;
        end

        req_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
